// ----- src/dlpd_pkg.sv -----
`default_nettype none

package dlpd_pkg;

  // Number of length digits that aborts the header.
  localparam int unsigned DIGIT_LIMIT = 4;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 10;
  localparam int unsigned DCNT_W  = 3;
  // Width of frame_length * 10 + 9 before saturation.
  localparam int unsigned PROD_W  = LEN_W + 4;

  localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
  localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_DIGITS = 3'd1,
    PH_LF     = 3'd2,
    PH_BRACE  = 3'd3,
    PH_BODY   = 3'd4
  } phase_t;

  // Result of one processed byte, from the parser to the output stage.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] payload_byte;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

// ----- src/dlpd_parser.sv -----
`default_nettype none

// Frame parser: holds the framing state and updates it once per step.
module dlpd_parser (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [dlpd_pkg::BYTE_W-1:0] in_byte,
  output dlpd_pkg::result_t                result,
  output dlpd_pkg::phase_t                 phase
);

  dlpd_pkg::phase_t                phase_r, phase_nxt;
  logic [dlpd_pkg::DCNT_W-1:0]     dcnt_r, dcnt_nxt;
  logic [dlpd_pkg::LEN_W-1:0]      len_r, len_nxt;
  logic [dlpd_pkg::LEN_W-1:0]      bcnt_r, bcnt_nxt;

  logic                            is_digit;
  logic [dlpd_pkg::PROD_W-1:0]     len_ext;
  logic [dlpd_pkg::PROD_W-1:0]     len_prod;
  logic [dlpd_pkg::LEN_W-1:0]      len_sat;
  logic [dlpd_pkg::DCNT_W-1:0]     dcnt_inc;
  logic [dlpd_pkg::LEN_W-1:0]      bcnt_inc;

  // Length accumulation: len * 10 + digit as two shifts and adds, saturated.
  always_comb begin
    is_digit = (in_byte >= dlpd_pkg::CH_ZERO) && (in_byte <= dlpd_pkg::CH_NINE);
    len_ext  = {{(dlpd_pkg::PROD_W - dlpd_pkg::LEN_W){1'b0}}, len_r};
    len_prod = (len_ext << 3) + (len_ext << 1)
             + {{(dlpd_pkg::PROD_W - 4){1'b0}}, in_byte[3:0]};
    len_sat  = (len_prod > {{(dlpd_pkg::PROD_W - dlpd_pkg::LEN_W){1'b0}}, dlpd_pkg::LEN_MAX})
             ? dlpd_pkg::LEN_MAX : len_prod[dlpd_pkg::LEN_W-1:0];
    dcnt_inc = dcnt_r + 1'b1;
    bcnt_inc = bcnt_r + 1'b1;
  end

  // Next state and result for the byte presented this step.
  always_comb begin
    phase_nxt           = phase_r;
    dcnt_nxt            = dcnt_r;
    len_nxt             = len_r;
    bcnt_nxt            = bcnt_r;
    result.valid        = 1'b0;
    result.payload_byte = in_byte;
    result.last         = 1'b0;
    unique case (phase_r)
      dlpd_pkg::PH_IDLE: begin
        if (in_byte == dlpd_pkg::CH_STAR) begin
          phase_nxt = dlpd_pkg::PH_DIGITS;
          dcnt_nxt  = '0;
          len_nxt   = '0;
        end
      end
      dlpd_pkg::PH_DIGITS: begin
        // Extra stars are skipped; unknown bytes are ignored.
        if (is_digit) begin
          len_nxt  = len_sat;
          dcnt_nxt = dcnt_inc;
          if (dcnt_inc >= dlpd_pkg::DCNT_W'(dlpd_pkg::DIGIT_LIMIT)) begin
            phase_nxt = dlpd_pkg::PH_IDLE;
          end
        end else if (in_byte == dlpd_pkg::CH_CR) begin
          bcnt_nxt  = '0;
          phase_nxt = dlpd_pkg::PH_LF;
        end
      end
      dlpd_pkg::PH_LF: begin
        phase_nxt = (in_byte == dlpd_pkg::CH_LF) ? dlpd_pkg::PH_BRACE : dlpd_pkg::PH_IDLE;
      end
      dlpd_pkg::PH_BRACE: begin
        if (in_byte == dlpd_pkg::CH_BRACE) begin
          phase_nxt    = dlpd_pkg::PH_BODY;
          bcnt_nxt     = dlpd_pkg::LEN_W'(1);
          result.valid = 1'b1;
        end else begin
          phase_nxt = dlpd_pkg::PH_IDLE;
        end
      end
      dlpd_pkg::PH_BODY: begin
        bcnt_nxt     = bcnt_inc;
        result.valid = 1'b1;
        if (bcnt_inc >= len_r) begin
          result.last = 1'b1;
          phase_nxt   = dlpd_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_nxt = dlpd_pkg::PH_IDLE;
      end
    endcase
  end

  // State registers advance only when a byte is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dlpd_pkg::PH_IDLE;
      dcnt_r  <= '0;
      len_r   <= '0;
      bcnt_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      dcnt_r  <= dcnt_nxt;
      len_r   <= len_nxt;
      bcnt_r  <= bcnt_nxt;
    end
  end

  assign phase = phase_r;

endmodule

`default_nettype wire

// ----- src/decimal_length_prefix_deframer_unit.sv -----
`default_nettype none

// Channel | Ports                                   | Direction
// --------+-----------------------------------------+----------
// input   | in_valid, in_ready, in_byte             | in
// result  | out_valid, out_ready, out_payload_byte, | out
//         | out_last                                |
//
// One byte per cycle while the output is not stalled: a byte is registered on
// transfer, parsed once the output register can take a result, and its result
// (if any) lands in the output register.
// Reset is synchronous and active low; it returns the parser to idle.
// A stalled output blocks the parse stage; the input register still takes
// a byte whenever it is empty or its byte is being parsed.
module decimal_length_prefix_deframer_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [dlpd_pkg::BYTE_W-1:0] in_byte,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [dlpd_pkg::BYTE_W-1:0] out_payload_byte,
  output      logic                        out_last
);

  logic                        in_valid_r;
  logic [dlpd_pkg::BYTE_W-1:0] in_byte_r;
  logic                        out_valid_r;
  logic [dlpd_pkg::BYTE_W-1:0] out_byte_r;
  logic                        out_last_r;
  logic                        advance;
  dlpd_pkg::result_t           result;
  dlpd_pkg::phase_t            phase;

  // The parse stage moves when it holds a byte and the output register can take a result.
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
  end

  dlpd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .in_byte (in_byte_r),
    .result  (result),
    .phase   (phase)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= result.valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      out_byte_r <= result.payload_byte;
      out_last_r <= result.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_byte_r;
  assign out_last         = out_last_r;

  // Results come only from the brace or body phases.
  a_result_phase: assert property (@(posedge clk) disable iff (!rst_n)
    advance && result.valid |->
      (phase == dlpd_pkg::PH_BRACE || phase == dlpd_pkg::PH_BODY))
    else $error("result produced outside payload phases");

  // The frame-closing byte returns the parser to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && result.valid && result.last |=> phase == dlpd_pkg::PH_IDLE)
    else $error("parser not idle after last byte");

  // An empty input register always accepts a transfer.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_ready)
    else $error("input stalled while empty");

  // A new result appears only from a parse step.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance))
    else $error("result valid without a parse step");

endmodule

`default_nettype wire
